FILE: hdl/euler_to_quaternion_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Euler angle to quaternion converter
// Shared helper macros for concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define E2Q_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define E2Q_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: hdl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Constants and the arctangent table for the Euler angle converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int CORDIC_W = 36;
    localparam int TRIG_W = 32;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q32 = 36'sd2608131496;
    localparam logic signed [TRIG_W-1:0] ONE_Q30 = 32'sd1073741824;

    // Arctangent of 2^-i in units of 2^-33 turn.
    function automatic logic signed [CORDIC_W-1:0] atan_step(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'd536870912;   1: t = 32'd316933406;
                2: t = 32'd167458907;   3: t = 32'd85004756;
                4: t = 32'd42667331;    5: t = 32'd21354465;
                6: t = 32'd10679838;    7: t = 32'd5340245;
                8: t = 32'd2670163;     9: t = 32'd1335087;
                10: t = 32'd667544;     11: t = 32'd333772;
                12: t = 32'd166886;     13: t = 32'd83443;
                14: t = 32'd41722;      15: t = 32'd20861;
                16: t = 32'd10430;      17: t = 32'd5215;
                18: t = 32'd2608;       19: t = 32'd1304;
                20: t = 32'd652;        21: t = 32'd326;
                22: t = 32'd163;        23: t = 32'd81;
                24: t = 32'd41;         25: t = 32'd20;
                26: t = 32'd10;         27: t = 32'd5;
                28: t = 32'd3;          29: t = 32'd1;
                30: t = 32'd1;
                default: t = 32'd0;
            endcase
            atan_step = $signed({3'b000, t, 1'b0});
        end
    endfunction

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } t_trig;

endpackage

FILE: hdl/e2q_cordic.sv
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of half the input angle.
// ----------------------------------------------------------------------------
module e2q_cordic
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [ANGLE_BITS-1:0] i_angle,
    output t_trig                        o_trig
);

    logic signed [CORDIC_W-1:0] r_x [TRIG_ITERATIONS+1];
    logic signed [CORDIC_W-1:0] r_y [TRIG_ITERATIONS+1];
    logic signed [CORDIC_W-1:0] r_z [TRIG_ITERATIONS+1];
    logic signed [CORDIC_W-1:0] n_z0;
    logic signed [CORDIC_W-1:0] w_xr;
    logic signed [CORDIC_W-1:0] w_yr;
    t_trig r_trig;

    // Half angle in units of 2^-33 turn.
    assign n_z0 = CORDIC_W'(i_angle) <<< (32 - ANGLE_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q32;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
        end
    end

    for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_step
        localparam int SH = g % 32;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][CORDIC_W-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> SH);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> SH);
                    r_z[g+1] <= r_z[g] - atan_step(SH);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> SH);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> SH);
                    r_z[g+1] <= r_z[g] + atan_step(SH);
                end
            end
        end
    end

    assign w_xr = (r_x[TRIG_ITERATIONS] + CORDIC_W'(2)) >>> 2;
    assign w_yr = (r_y[TRIG_ITERATIONS] + CORDIC_W'(2)) >>> 2;

    function automatic logic signed [TRIG_W-1:0] clamp(input logic signed [CORDIC_W-1:0] v);
        if (v > CORDIC_W'(ONE_Q30))       clamp = ONE_Q30;
        else if (v < -CORDIC_W'(ONE_Q30)) clamp = -ONE_Q30;
        else                               clamp = v[TRIG_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.c <= clamp(w_xr);
            r_trig.s <= clamp(w_yr);
        end
    end

    assign o_trig = r_trig;

endmodule

FILE: hdl/e2q_combine.sv
// ----------------------------------------------------------------------------
// e2q_combine
// Products of the half-angle terms, sums and output rounding.
// ----------------------------------------------------------------------------
module e2q_combine
    import e2q_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  t_trig                           i_tx,
    input  t_trig                           i_ty,
    input  t_trig                           i_tz,
    output logic signed [FRACTION_BITS+1:0] o_r,
    output logic signed [FRACTION_BITS+1:0] o_i,
    output logic signed [FRACTION_BITS+1:0] o_j,
    output logic signed [FRACTION_BITS+1:0] o_k
);

    localparam int OW = FRACTION_BITS + 2;
    localparam int SH = 60 - FRACTION_BITS;

    // Stage 1: first products, rounded to Q30 (slots: cz*cx, sz*sx, cz*sx, sz*cx).
    logic signed [33:0] r_ab [4];
    t_trig r_y1;
    // Stage 2: Q60 terms.
    logic signed [66:0] r_t [8];
    // Stage 3: sums.
    logic signed [67:0] r_s [4];
    logic signed [OW-1:0] r_o [4];

    function automatic logic signed [33:0] mulr(input logic signed [TRIG_W-1:0] a,
                                               input logic signed [TRIG_W-1:0] b);
        logic signed [63:0] p;
        begin
            p = a * b;
            mulr = 34'((p + 64'sd536870912) >>> 30);
        end
    endfunction

    function automatic logic signed [OW-1:0] fin(input logic signed [67:0] v);
        logic signed [67:0] q;
        begin
            q = (v + (68'sd1 <<< (SH - 1))) >>> SH;
            if (q > (68'sd1 <<< FRACTION_BITS))       fin = OW'(1) <<< FRACTION_BITS;
            else if (q < -(68'sd1 <<< FRACTION_BITS)) fin = -(OW'(1) <<< FRACTION_BITS);
            else                                       fin = q[OW-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ab[0] <= mulr(i_tz.c, i_tx.c);
            r_ab[1] <= mulr(i_tz.s, i_tx.s);
            r_ab[2] <= mulr(i_tz.c, i_tx.s);
            r_ab[3] <= mulr(i_tz.s, i_tx.c);
            r_y1 <= i_ty;
            r_t[0] <= r_ab[0] * r_y1.c;
            r_t[1] <= r_ab[1] * r_y1.s;
            r_t[2] <= r_ab[2] * r_y1.c;
            r_t[3] <= r_ab[3] * r_y1.s;
            r_t[4] <= r_ab[0] * r_y1.s;
            r_t[5] <= r_ab[1] * r_y1.c;
            r_t[6] <= r_ab[3] * r_y1.c;
            r_t[7] <= r_ab[2] * r_y1.s;
            r_s[0] <= 68'(r_t[0]) + 68'(r_t[1]);
            r_s[1] <= 68'(r_t[2]) + 68'(r_t[3]);
            r_s[2] <= 68'(r_t[4]) - 68'(r_t[5]);
            r_s[3] <= 68'(r_t[6]) - 68'(r_t[7]);
            for (int n = 0; n < 4; n++) r_o[n] <= fin(r_s[n]);
        end
    end

    assign o_r = r_o[0];
    assign o_i = r_o[1];
    assign o_j = r_o[2];
    assign o_k = r_o[3];

endmodule

FILE: hdl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Converts three binary rotation angles into a unit quaternion.
// ----------------------------------------------------------------------------
// The block takes one angle triple per cycle and returns the quaternion through
// its pipeline registers in order: the CORDIC load, TRIG_ITERATIONS unrolled
// CORDIC steps, the rounding of the trig values, and the products, Q60 terms,
// sums and saturated Q1.16 outputs. The whole pipeline advances together whenever
// the output stage is empty or being drained, so a stall at the output holds
// every item in place and throughput is one item per cycle while the consumer
// keeps up.
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRACTION_BITS = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [ANGLE_BITS-1:0]    i_angle_x,
    input  logic signed [ANGLE_BITS-1:0]    i_angle_y,
    input  logic signed [ANGLE_BITS-1:0]    i_angle_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [FRACTION_BITS+1:0] o_quat_real,
    output logic signed [FRACTION_BITS+1:0] o_quat_i,
    output logic signed [FRACTION_BITS+1:0] o_quat_j,
    output logic signed [FRACTION_BITS+1:0] o_quat_k
);
`include "euler_to_quaternion_defines.svh"

    localparam int LAT = TRIG_ITERATIONS + 6;

    logic [LAT-1:0] r_vld;
    logic w_en;
    t_trig w_tx, w_ty, w_tz;

    // The pipeline moves when its last stage is free or being taken.
    assign w_en = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cx (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_x), .o_trig(w_tx));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cy (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_y), .o_trig(w_ty));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cz (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_z), .o_trig(w_tz));

    e2q_combine #(.FRACTION_BITS(FRACTION_BITS)) u_comb (
        .i_clk(i_clk), .i_en(w_en), .i_tx(w_tx), .i_ty(w_ty), .i_tz(w_tz),
        .o_r(o_quat_real), .o_i(o_quat_i), .o_j(o_quat_j), .o_k(o_quat_k));

    `E2Q_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !r_vld[LAT-1], o_ready)
    `E2Q_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `E2Q_ASSERT_NEXT(a_shift, i_clk, i_rst_n, w_en, r_vld[0] == $past(i_valid))

endmodule
